// ===== rtl/core/gwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_pkg: shared definitions for the glob wildcard matcher
// Element store sizing, request mode codes, pattern characters and the
// structures that pass between the parser, the element store and the NFA.
// ----------------------------------------------------------------------------
package gwm_pkg;

	localparam int MAX_ELEMENTS = 32;
	localparam int NPOS         = MAX_ELEMENTS + 1;
	localparam int CNT_W        = $clog2(NPOS);
	localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int LVLS         = $clog2(NPOS);

	typedef enum logic [1:0] {
		MODE_PAT_BYTE  = 2'd0,
		MODE_PAT_END   = 2'd1,
		MODE_SUBJ_BYTE = 2'd2,
		MODE_SUBJ_END  = 2'd3
	} mode_t;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DASH   = 8'h2D;

	typedef logic [255:0] byte_set_t;

	typedef struct packed {
		logic             en;
		logic             star;
		logic [IDX_W-1:0] idx;
		byte_set_t        set;
	} commit_t;

	typedef struct packed {
		logic             closed;
		logic             ovf;
		logic [CNT_W-1:0] count;
	} pat_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/glob_wildcard_matcher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_unit: glob pattern matcher, one byte per cycle unless stalled
// Parses a glob pattern into elements and matches subject strings against it
// with a position-set vector; each end of subject returns one result.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  request   req_valid/req_stall   mode, byte_value
//  result    res_valid/res_stall   matched, pattern_overflow
//
// Each request is registered, then handled by the parser, the element lanes and
// the closure network; one request per cycle is sustained while req_stall is low.
// A result is registered in the cycle after its end-of-subject request is handled.
// req_stall rises only while an end-of-subject request waits for a stalled
// result register; all other requests keep flowing.
// After reset the empty pattern is loaded and position zero is active.
module glob_wildcard_matcher_unit import gwm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] byte_value,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            matched,
	output logic            pattern_overflow
);

	logic                    valid_s1;
	mode_t                   mode_s1;
	logic [7:0]              byte_s1;
	logic                    adv;
	logic                    fire;
	logic                    res_valid_q;
	logic                    matched_q;
	logic                    ovf_q;
	commit_t                 commit;
	pat_status_t             status;
	logic [MAX_ELEMENTS-1:0] star_vec;
	logic [MAX_ELEMENTS-1:0] hit_vec;
	logic                    end_active;

	assign adv       = !(mode_s1 == MODE_SUBJ_END && res_valid_q && res_stall);
	assign fire      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			mode_s1 <= mode_t'(mode);
			byte_s1 <= byte_value;
		end
	end

	gwm_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.mode       (mode_s1),
		.byte_value (byte_s1),
		.commit     (commit),
		.status     (status)
	);

	gwm_elem_store u_store (
		.clk        (clk),
		.commit     (commit),
		.byte_value (byte_s1),
		.star_vec   (star_vec),
		.hit_vec    (hit_vec)
	);

	gwm_nfa u_nfa (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.mode       (mode_s1),
		.byte_value (byte_s1),
		.status     (status),
		.star_vec   (star_vec),
		.hit_vec    (hit_vec),
		.end_active (end_active)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && mode_s1 == MODE_SUBJ_END) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && mode_s1 == MODE_SUBJ_END) begin
			matched_q <= status.closed && !status.ovf && end_active;
			ovf_q     <= status.ovf;
		end
	end

	assign res_valid        = res_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = ovf_q;

	// Requests are held back only behind a blocked end-of-subject request.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && mode_s1 == MODE_SUBJ_END && res_valid_q && res_stall)
		else $error("request stalled without a blocked result");

	// Every handled end-of-subject request leaves a result in the register.
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode_s1 == MODE_SUBJ_END |=> res_valid_q)
		else $error("end of subject produced no result");

	// An overflowed pattern never reports a match.
	a_no_ovf_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && matched_q |-> !ovf_q)
		else $error("match reported on overflowed pattern");

endmodule
`default_nettype wire

// ===== rtl/core/gwm_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_parser: pattern parser
// Turns pattern bytes into star, any-byte, literal and bracket class elements,
// tracks the element count and the overflow flag, and issues element writes.
// ----------------------------------------------------------------------------
module gwm_parser import gwm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire mode_t       mode,
	input  wire logic [7:0]  byte_value,
	output commit_t          commit,
	output pat_status_t      status
);

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             closed_q;
	logic             in_class_q;
	logic             at_start_q;
	logic             neg_q;
	logic             dash_q;
	logic [7:0]       prev_q;
	byte_set_t        scratch_q;

	logic             start;
	logic [CNT_W-1:0] c_count;
	logic             c_ovf, c_in_class, c_at_start, c_neg, c_dash;
	logic [7:0]       c_prev;
	logic [CNT_W-1:0] n_count;
	logic             n_ovf, n_closed, n_in_class, n_at_start, n_neg, n_dash;
	logic [7:0]       n_prev;
	byte_set_t        n_scratch;
	byte_set_t        add_set;
	byte_set_t        range_set;
	logic             clr_scratch;
	logic             close_req;
	logic             commit_req;
	logic             commit_star;
	byte_set_t        commit_set;
	logic             has_room;

	always_comb begin
		range_set[0] = 1'b0;
		for (int c = 1; c < 256; c++) begin
			range_set[c] = ($signed(8'(c)) >= $signed(c_prev)) &&
				($signed(8'(c)) <= $signed(byte_value));
		end
	end

	always_comb begin
		start = fire && closed_q &&
			((mode == MODE_PAT_BYTE && byte_value != 8'd0) || mode == MODE_PAT_END);
		c_count    = start ? '0 : count_q;
		c_ovf      = start ? 1'b0 : ovf_q;
		c_in_class = start ? 1'b0 : in_class_q;
		c_at_start = start ? 1'b0 : at_start_q;
		c_neg      = start ? 1'b0 : neg_q;
		c_dash     = start ? 1'b0 : dash_q;
		c_prev     = start ? 8'd0 : prev_q;

		n_count     = c_count;
		n_ovf       = c_ovf;
		n_closed    = closed_q && !start;
		n_in_class  = c_in_class;
		n_at_start  = c_at_start;
		n_neg       = c_neg;
		n_dash      = c_dash;
		n_prev      = c_prev;
		add_set     = '0;
		clr_scratch = 1'b0;
		close_req   = 1'b0;
		commit_req  = 1'b0;
		commit_star = 1'b0;
		commit_set  = '0;

		if (fire) begin
			unique case (mode)
				MODE_PAT_BYTE: begin
					if (byte_value != 8'd0) begin
						if (c_in_class) begin
							if (c_at_start && (byte_value == CH_BANG ||
								byte_value == CH_CARET)) begin
								n_at_start = 1'b0;
								n_neg      = 1'b1;
							end else begin
								n_at_start = 1'b0;
								if (c_dash) begin
									n_dash = 1'b0;
									if (byte_value == CH_RBRACK) begin
										add_set[CH_DASH] = 1'b1;
										close_req        = 1'b1;
									end else begin
										add_set = range_set;
										n_prev  = byte_value;
									end
								end else if (byte_value == CH_RBRACK) begin
									close_req = 1'b1;
								end else if (byte_value == CH_DASH && c_prev != 8'd0) begin
									n_dash = 1'b1;
								end else begin
									add_set[byte_value] = 1'b1;
									n_prev              = byte_value;
								end
							end
						end else if (byte_value == CH_STAR) begin
							commit_req  = 1'b1;
							commit_star = 1'b1;
						end else if (byte_value == CH_QUEST) begin
							commit_req = 1'b1;
							commit_set = '1;
						end else if (byte_value == CH_LBRACK) begin
							n_in_class  = 1'b1;
							n_at_start  = 1'b1;
							n_neg       = 1'b0;
							n_prev      = 8'd0;
							n_dash      = 1'b0;
							clr_scratch = 1'b1;
						end else begin
							commit_req             = 1'b1;
							commit_set[byte_value] = 1'b1;
						end
					end
				end
				MODE_PAT_END: begin
					if (c_in_class) begin
						add_set[CH_DASH] = c_dash;
						close_req        = 1'b1;
					end
					n_closed = 1'b1;
				end
				default: begin
				end
			endcase
		end

		n_scratch = (clr_scratch ? '0 : scratch_q) | add_set;

		if (close_req) begin
			commit_req = 1'b1;
			commit_set = c_neg ? ~n_scratch : n_scratch;
			n_in_class = 1'b0;
			n_at_start = 1'b0;
			n_neg      = 1'b0;
			n_dash     = 1'b0;
			n_prev     = 8'd0;
		end

		has_room = c_count < CNT_W'(MAX_ELEMENTS);
		if (commit_req) begin
			if (has_room) begin
				n_count = c_count + CNT_W'(1);
			end else begin
				n_ovf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			closed_q   <= 1'b1;
			in_class_q <= 1'b0;
			at_start_q <= 1'b0;
			neg_q      <= 1'b0;
			dash_q     <= 1'b0;
			prev_q     <= 8'd0;
		end else begin
			count_q    <= n_count;
			ovf_q      <= n_ovf;
			closed_q   <= n_closed;
			in_class_q <= n_in_class;
			at_start_q <= n_at_start;
			neg_q      <= n_neg;
			dash_q     <= n_dash;
			prev_q     <= n_prev;
		end
	end

	always_ff @(posedge clk) begin
		scratch_q <= n_scratch;
	end

	assign commit.en   = commit_req && has_room;
	assign commit.star = commit_star;
	assign commit.idx  = c_count[IDX_W-1:0];
	assign commit.set  = commit_set;

	assign status.closed = closed_q;
	assign status.ovf    = ovf_q;
	assign status.count  = count_q;

	// The element count never runs past the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count beyond store depth");

	// Overflow is only flagged once the store is full.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CNT_W'(MAX_ELEMENTS))
		else $error("overflow flagged with room left");

	// A bracket class is only ever open while the pattern is open.
	a_class_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_class_q |-> !closed_q)
		else $error("class open on a closed pattern");

endmodule
`default_nettype wire

// ===== rtl/core/gwm_elem_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_elem_store: pattern element store
// One lane per element holds its star bit and 256-bit byte set; every lane
// looks up the current subject byte in its own set.
// ----------------------------------------------------------------------------
module gwm_elem_store import gwm_pkg::*; (
	input  wire logic                    clk,
	input  wire commit_t                 commit,
	input  wire logic [7:0]              byte_value,
	output logic [MAX_ELEMENTS-1:0]      star_vec,
	output logic [MAX_ELEMENTS-1:0]      hit_vec
);

	byte_set_t set_q  [MAX_ELEMENTS];
	logic      star_q [MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (commit.en) begin
			set_q[commit.idx]  <= commit.set;
			star_q[commit.idx] <= commit.star;
		end
	end

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_lane
		assign star_vec[i] = star_q[i];
		assign hit_vec[i]  = set_q[i][byte_value];
	end

endmodule
`default_nettype wire

// ===== rtl/core/gwm_nfa.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gwm_nfa: position-set matcher
// Holds the active position vector before star closure; the closure is a
// prefix network over the star bits, and each subject byte steps the vector.
// ----------------------------------------------------------------------------
module gwm_nfa import gwm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    fire,
	input  wire mode_t                   mode,
	input  wire logic [7:0]              byte_value,
	input  wire pat_status_t             status,
	input  wire logic [MAX_ELEMENTS-1:0] star_vec,
	input  wire logic [MAX_ELEMENTS-1:0] hit_vec,
	output logic                         end_active
);

	logic [NPOS-1:0]         raw_q;
	logic [MAX_ELEMENTS-1:0] lane_on;
	logic [NPOS-1:0]         gl [LVLS+1];
	logic [NPOS-1:0]         pl [LVLS+1];
	logic [NPOS-1:0]         eff;
	logic [NPOS-1:0]         step;

	always_comb begin
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			lane_on[i] = CNT_W'(i) < status.count;
		end
		gl[0]    = raw_q;
		pl[0][0] = 1'b0;
		for (int j = 1; j < NPOS; j++) begin
			pl[0][j] = star_vec[j-1] && lane_on[j-1];
		end
		for (int k = 0; k < LVLS; k++) begin
			for (int j = 0; j < NPOS; j++) begin
				if (j >= (1 << k)) begin
					gl[k+1][j] = gl[k][j] | (pl[k][j] & gl[k][j-(1<<k)]);
					pl[k+1][j] = pl[k][j] & pl[k][j-(1<<k)];
				end else begin
					gl[k+1][j] = gl[k][j];
					pl[k+1][j] = pl[k][j];
				end
			end
		end
		eff = gl[LVLS];

		step = '0;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			if (eff[i] && lane_on[i]) begin
				if (star_vec[i]) begin
					step[i] = 1'b1;
				end else if (hit_vec[i]) begin
					step[i+1] = 1'b1;
				end
			end
		end
	end

	assign end_active = eff[status.count];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= NPOS'(1);
		end else if (fire) begin
			unique case (mode)
				MODE_PAT_END: begin
					raw_q <= NPOS'(1);
				end
				MODE_SUBJ_BYTE: begin
					if (status.closed && byte_value != 8'd0) begin
						raw_q <= step;
					end
				end
				MODE_SUBJ_END: begin
					if (status.closed) begin
						raw_q <= NPOS'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire
